>>> rtl/point_in_primitive_test_assert.svh
// Assertion macros for the point-in-primitive test block.
`ifndef POINT_IN_PRIMITIVE_TEST_ASSERT_SVH
`define POINT_IN_PRIMITIVE_TEST_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define PIPT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("point_in_primitive_test: implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define PIPT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("point_in_primitive_test: next-cycle check failed");
`else
`define PIPT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PIPT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/pipt_pkg.sv
// Types, constants and helpers for the point-in-primitive test pipeline.
package pipt_pkg;

    localparam int COORD_W   = 32;
    localparam int DIM_W     = 31;
    localparam int TOL_W     = 16;
    localparam int IDX_W     = 3;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 8;
    localparam int NSTAGE    = 5;

    typedef enum logic [2:0] {
        KIND_RECT2D   = 3'd0,
        KIND_CIRCLE   = 3'd1,
        KIND_TRIANGLE = 3'd2,
        KIND_BOX      = 3'd3,
        KIND_SPHERE   = 3'd4,
        KIND_CONE     = 3'd5,
        KIND_CYLINDER = 3'd6
    } shape_kind_t;

    typedef enum logic [IDX_W-1:0] {
        CFG_SHAPE_KIND     = 3'd0,
        CFG_DIM_A          = 3'd1,
        CFG_DIM_B          = 3'd2,
        CFG_DIM_C          = 3'd3,
        CFG_FLAT_TOLERANCE = 3'd4
    } cfg_index_t;

    // Per-point bound checks, settled at the pipeline entry.
    typedef struct packed {
        logic cx;     // 2|x| < a
        logic cyb;    // 2|y| < b
        logic czb;    // 2|z| < b
        logic czc;    // 2|z| < c
        logic flat;   // |y| < tolerance
    } flags_t;

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [31:0] span;   // 2z + b, meaningful when 2|z| < b
        flags_t      f;
    } stage1_t;

    typedef struct packed {
        logic [63:0] sq_x;
        logic [63:0] sq_y;
        logic [63:0] sq_z;
        logic [61:0] a2;
        logic [63:0] b2sq;   // (2b)^2
        logic [62:0] rs;     // a * span
        logic [62:0] bax;    // b * |x|
        flags_t      f;
    } stage2_t;

    typedef struct packed {
        logic [63:0] s2;
        logic [63:0] sq_z;
        logic [61:0] a2;
        logic [63:0] b2sq;
        logic [63:0] pp_ll;
        logic [62:0] pp_lh;
        logic [61:0] pp_hh;
        logic        tri_in;
        flags_t      f;
    } stage3_t;

    typedef struct packed {
        logic [63:0]  q_ll;
        logic [63:0]  q_lh;
        logic [63:0]  q_hl;
        logic [63:0]  q_hh;
        logic [127:0] rhs;
        logic         sph;
        logic         cyl;
        logic         tri_in;
        flags_t       f;
    } stage4_t;

    typedef struct packed {
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic         sph;
        logic         cyl;
        logic         tri_in;
        flags_t       f;
    } stage5_t;

    // Exact magnitude of a signed word; -2^31 gives 2^31.
    function automatic logic [COORD_W-1:0] mag32(input logic [COORD_W-1:0] v);
        return v[COORD_W-1] ? (~v + 32'd1) : v;
    endfunction

endpackage

>>> rtl/point_in_primitive_test.sv
// Point-in-primitive test: six-stage pipeline, strict inside flag per point.
// Accepts one request per cycle unless a stall on m_tready holds the pipe.
// The six register stages are magnitudes, 32x32 products, partials,
// compares, sums and the output select; every product is at most 32x32.
// A stall on m_tready freezes every stage together; nothing is lost or repeated.
// aresetn (sync, active low) empties the pipe and loads the default shape.
`include "point_in_primitive_test_assert.svh"

module point_in_primitive_test (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [pipt_pkg::IDX_W-1:0]      cfg_index,
    input  logic [pipt_pkg::DIM_W-1:0]      cfg_wdata,
    // point requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pipt_pkg::S_TDATA_W-1:0]  s_tdata,   // pos_x, pos_y, pos_z
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pipt_pkg::M_TDATA_W-1:0]  m_tdata    // inside_res, config_error, zeros
);

    // ---------------------------------------------------------------------
    // Configuration registers. The user writes them only with the pipe empty;
    // the block itself does not enforce this. Every stage reads them directly.
    // ---------------------------------------------------------------------
    pipt_pkg::shape_kind_t          shape_kind_reg;
    logic [pipt_pkg::DIM_W-1:0]     dim_a_reg;
    logic [pipt_pkg::DIM_W-1:0]     dim_b_reg;
    logic [pipt_pkg::DIM_W-1:0]     dim_c_reg;
    logic [pipt_pkg::TOL_W-1:0]     flat_tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_kind_reg <= pipt_pkg::KIND_RECT2D;
            dim_a_reg      <= 31'd65536;
            dim_b_reg      <= 31'd65536;
            dim_c_reg      <= 31'd65536;
            flat_tol_reg   <= 16'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pipt_pkg::CFG_SHAPE_KIND:
                    shape_kind_reg <= pipt_pkg::shape_kind_t'(cfg_wdata[2:0]);
                pipt_pkg::CFG_DIM_A:          dim_a_reg    <= cfg_wdata;
                pipt_pkg::CFG_DIM_B:          dim_b_reg    <= cfg_wdata;
                pipt_pkg::CFG_DIM_C:          dim_c_reg    <= cfg_wdata;
                pipt_pkg::CFG_FLAT_TOLERANCE: flat_tol_reg <= cfg_wdata[pipt_pkg::TOL_W-1:0];
                default: ;   // indexes beyond the list are ignored
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline control: one global advance; all stages move together.
    // ---------------------------------------------------------------------
    logic                          advance;
    logic [pipt_pkg::NSTAGE-1:0]   vld_reg;
    logic [pipt_pkg::NSTAGE-1:0]   vld_next;
    logic                          m_tvalid_reg;
    logic                          last_vld;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;
    assign vld_next = {vld_reg[pipt_pkg::NSTAGE-2:0], s_tvalid};
    assign last_vld = vld_reg[pipt_pkg::NSTAGE-1];

    // ---------------------------------------------------------------------
    // Stage 1: magnitudes, span and the linear bound checks.
    // All tests scale alike in the fixed-point format, so the fraction
    // width never enters the arithmetic; factors of two are shifts.
    // ---------------------------------------------------------------------
    pipt_pkg::stage1_t st1_next, st1_reg;
    logic [31:0] pos_x, pos_y, pos_z;
    logic [31:0] ax, ay, az;
    logic [33:0] span_w;

    assign pos_x = s_tdata[31:0];
    assign pos_y = s_tdata[63:32];
    assign pos_z = s_tdata[95:64];

    always_comb begin
        ax     = pipt_pkg::mag32(pos_x);
        ay     = pipt_pkg::mag32(pos_y);
        az     = pipt_pkg::mag32(pos_z);
        span_w = {pos_z[31], pos_z, 1'b0} + {3'b000, dim_b_reg};

        st1_next.ax     = ax;
        st1_next.ay     = ay;
        st1_next.az     = az;
        st1_next.span   = span_w[31:0];
        st1_next.f.cx   = {ax, 1'b0} < {2'b00, dim_a_reg};
        st1_next.f.cyb  = {ay, 1'b0} < {2'b00, dim_b_reg};
        st1_next.f.czb  = {az, 1'b0} < {2'b00, dim_b_reg};
        st1_next.f.czc  = {az, 1'b0} < {2'b00, dim_c_reg};
        st1_next.f.flat = ay < {16'd0, flat_tol_reg};
    end

    // ---------------------------------------------------------------------
    // Stage 2: the 32x32 products.
    // ---------------------------------------------------------------------
    pipt_pkg::stage2_t st2_next, st2_reg;
    logic [31:0] b2;

    always_comb begin
        b2            = {dim_b_reg, 1'b0};
        st2_next.sq_x = 64'(st1_reg.ax) * 64'(st1_reg.ax);
        st2_next.sq_y = 64'(st1_reg.ay) * 64'(st1_reg.ay);
        st2_next.sq_z = 64'(st1_reg.az) * 64'(st1_reg.az);
        st2_next.a2   = 62'(dim_a_reg) * 62'(dim_a_reg);
        st2_next.b2sq = 64'(b2) * 64'(b2);
        st2_next.rs   = 63'(dim_a_reg) * 63'(st1_reg.span);
        st2_next.bax  = 63'(dim_b_reg) * 63'(st1_reg.ax);
        st2_next.f    = st1_reg.f;
    end

    // ---------------------------------------------------------------------
    // Stage 3: x^2 + y^2, triangle edge test, partials of (a*span)^2.
    // ---------------------------------------------------------------------
    pipt_pkg::stage3_t st3_next, st3_reg;

    always_comb begin
        st3_next.s2     = st2_reg.sq_x + st2_reg.sq_y;   // at most 2^63
        st3_next.sq_z   = st2_reg.sq_z;
        st3_next.a2     = st2_reg.a2;
        st3_next.b2sq   = st2_reg.b2sq;
        st3_next.pp_ll  = 64'(st2_reg.rs[31:0]) * 64'(st2_reg.rs[31:0]);
        st3_next.pp_lh  = 63'(st2_reg.rs[31:0]) * 63'(st2_reg.rs[62:32]);
        st3_next.pp_hh  = 62'(st2_reg.rs[62:32]) * 62'(st2_reg.rs[62:32]);
        st3_next.tri_in = {st2_reg.bax, 2'b00} < {2'b00, st2_reg.rs};
        st3_next.f      = st2_reg.f;
    end

    // ---------------------------------------------------------------------
    // Stage 4: radial compares, cone RHS sum, partials of (2b)^2 * s2.
    // ---------------------------------------------------------------------
    pipt_pkg::stage4_t st4_next, st4_reg;
    logic [64:0] s3;

    always_comb begin
        s3              = {1'b0, st3_reg.s2} + {1'b0, st3_reg.sq_z};
        st4_next.sph    = s3 < 65'(st3_reg.a2);
        st4_next.cyl    = st3_reg.s2 < 64'(st3_reg.a2);
        st4_next.q_ll   = 64'(st3_reg.b2sq[31:0])  * 64'(st3_reg.s2[31:0]);
        st4_next.q_lh   = 64'(st3_reg.b2sq[31:0])  * 64'(st3_reg.s2[63:32]);
        st4_next.q_hl   = 64'(st3_reg.b2sq[63:32]) * 64'(st3_reg.s2[31:0]);
        st4_next.q_hh   = 64'(st3_reg.b2sq[63:32]) * 64'(st3_reg.s2[63:32]);
        // cross term appears twice, hence the shift by 33
        st4_next.rhs    = (128'(st3_reg.pp_hh) << 64) + (128'(st3_reg.pp_lh) << 33)
                        + 128'(st3_reg.pp_ll);
        st4_next.tri_in = st3_reg.tri_in;
        st4_next.f      = st3_reg.f;
    end

    // ---------------------------------------------------------------------
    // Stage 5: cone LHS sum.
    // ---------------------------------------------------------------------
    pipt_pkg::stage5_t st5_next, st5_reg;

    always_comb begin
        st5_next.lhs    = (128'(st4_reg.q_hh) << 64) + (128'(st4_reg.q_lh) << 32)
                        + (128'(st4_reg.q_hl) << 32) + 128'(st4_reg.q_ll);
        st5_next.rhs    = st4_reg.rhs;
        st5_next.sph    = st4_reg.sph;
        st5_next.cyl    = st4_reg.cyl;
        st5_next.tri_in = st4_reg.tri_in;
        st5_next.f      = st4_reg.f;
    end

    // ---------------------------------------------------------------------
    // Stage 6: cone compare, per-kind selection, dimension check.
    // ---------------------------------------------------------------------
    logic cone_in;
    logic inside_next, err_next;
    logic inside_reg, err_reg;
    logic a_zero, b_zero, c_zero;

    assign a_zero = (dim_a_reg == '0);
    assign b_zero = (dim_b_reg == '0);
    assign c_zero = (dim_c_reg == '0);

    always_comb begin
        logic hit;
        cone_in = st5_reg.lhs < st5_reg.rhs;
        hit     = 1'b0;
        err_next = 1'b0;
        unique case (shape_kind_reg)
            pipt_pkg::KIND_RECT2D: begin
                err_next = a_zero || b_zero;
                hit = st5_reg.f.cx && st5_reg.f.czb && st5_reg.f.flat;
            end
            pipt_pkg::KIND_CIRCLE: begin
                err_next = a_zero;
                hit = st5_reg.sph && st5_reg.f.flat;
            end
            pipt_pkg::KIND_TRIANGLE: begin
                err_next = a_zero || b_zero;
                hit = st5_reg.f.flat && st5_reg.f.czb && st5_reg.f.cx && st5_reg.tri_in;
            end
            pipt_pkg::KIND_BOX: begin
                err_next = a_zero || b_zero || c_zero;
                hit = st5_reg.f.cx && st5_reg.f.cyb && st5_reg.f.czc;
            end
            pipt_pkg::KIND_SPHERE: begin
                err_next = a_zero;
                hit = st5_reg.sph;
            end
            pipt_pkg::KIND_CONE: begin
                err_next = a_zero || b_zero;
                hit = st5_reg.f.czb && cone_in;
            end
            pipt_pkg::KIND_CYLINDER: begin
                err_next = a_zero || b_zero;
                hit = st5_reg.f.czb && st5_reg.cyl;
            end
            default: begin
                // unused kind code
                err_next = 1'b1;
                hit = 1'b0;
            end
        endcase
        inside_next = hit && !err_next;
    end

    // ---------------------------------------------------------------------
    // Registers: valid bits reset, payload does not.
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            vld_reg      <= vld_next;
            m_tvalid_reg <= vld_reg[pipt_pkg::NSTAGE-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st1_reg    <= st1_next;
            st2_reg    <= st2_next;
            st3_reg    <= st3_next;
            st4_reg    <= st4_next;
            st5_reg    <= st5_next;
            inside_reg <= inside_next;
            err_reg    <= err_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, err_reg, inside_reg};

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // a stalled last stage keeps its request
    `PIPT_ASSERT_NXT(a_stall_holds, aclk, aresetn, last_vld && !advance, last_vld)
    // a moving last stage always produces a result
    `PIPT_ASSERT_NXT(a_drain_to_out, aclk, aresetn, last_vld && advance, m_tvalid)
    // a point is never reported inside a badly dimensioned shape
    `PIPT_ASSERT_IMP(a_err_not_inside, aclk, aresetn, m_tvalid && m_tdata[1], !m_tdata[0])

endmodule

>>> dv/point_in_primitive_test_tb.sv
// Self-checking testbench for the point-in-primitive test block.
module point_in_primitive_test_tb;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 10;
    localparam int QUIET_LIMIT  = 1000;   // cycles with no handshake on either side
    localparam int HOLD_CYCLES  = 48;     // long sink hold-off, well past the pipe depth
    localparam int INSIDE_BIT   = 0;      // m_tdata bit positions
    localparam int ERROR_BIT    = 1;

    localparam logic [2:0] KIND_UNUSED = 3'd7;       // no shape, always flags an error
    localparam logic [pipt_pkg::DIM_W-1:0] DIM_MAX = {pipt_pkg::DIM_W{1'b1}};
    localparam logic [31:0] ONE      = 32'h0001_0000;   // 1.0 in Q16.16
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;

    typedef struct packed {
        logic in_shape;
        logic cfg_err;
    } verdict_t;

    logic                               aclk = 1'b0;
    logic                               aresetn;
    logic                               cfg_we;
    logic [pipt_pkg::IDX_W-1:0]         cfg_index;
    logic [pipt_pkg::DIM_W-1:0]         cfg_wdata;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [pipt_pkg::S_TDATA_W-1:0]     s_tdata;     // pos_x, pos_y, pos_z
    logic                               m_tvalid;
    logic                               m_tready;
    logic [pipt_pkg::M_TDATA_W-1:0]     m_tdata;     // inside_res, config_error, zeros

    // Shadow copy of the shape registers, kept in step with every write.
    logic [2:0]                   kind_r;
    logic [pipt_pkg::DIM_W-1:0]   dim_a_r;
    logic [pipt_pkg::DIM_W-1:0]   dim_b_r;
    logic [pipt_pkg::DIM_W-1:0]   dim_c_r;
    logic [pipt_pkg::TOL_W-1:0]   tol_r;

    verdict_t pending_verdicts[$];   // one per accepted request, oldest first
    int       fail_count;
    int       src_idle_pct;          // chance of a gap before each request
    int       sink_idle_pct;         // chance of a stall on m_tready per cycle
    logic     hold_request;          // asks the sink for one long hold-off

    point_in_primitive_test i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction. Everything is widened to 128 bits so no square or
    // cross-product can wrap; magnitudes are exact, -2^31 included.
    // ------------------------------------------------------------------
    function automatic verdict_t classify_point(logic [31:0] px, logic [31:0] py,
                                                logic [31:0] pz);
        logic [127:0] ax, ay, az, a, b, c, s2, s3, span;
        logic         flat_ok;
        verdict_t     v;
        ax = px[31] ? (128'h1_0000_0000 - 128'(px)) : 128'(px);
        ay = py[31] ? (128'h1_0000_0000 - 128'(py)) : 128'(py);
        az = pz[31] ? (128'h1_0000_0000 - 128'(pz)) : 128'(pz);
        a  = 128'(dim_a_r);
        b  = 128'(dim_b_r);
        c  = 128'(dim_c_r);
        flat_ok = ay < 128'(tol_r);
        s2 = ax * ax + ay * ay;
        s3 = s2 + az * az;
        // 2z + b; only looked at once 2|z| < b holds, so it is then positive
        span = pz[31] ? (b - 2 * az) : (b + 2 * az);
        v = '0;
        case (kind_r)
            pipt_pkg::KIND_RECT2D: begin
                v.cfg_err  = (a == 0) || (b == 0);
                v.in_shape = (2 * ax < a) && (2 * az < b) && flat_ok;
            end
            pipt_pkg::KIND_CIRCLE: begin
                v.cfg_err  = (a == 0);
                v.in_shape = (s3 < a * a) && flat_ok;
            end
            pipt_pkg::KIND_TRIANGLE: begin
                // apex at -z edge centre widening to full width at +z
                v.cfg_err  = (a == 0) || (b == 0);
                v.in_shape = flat_ok && (2 * az < b) && (2 * ax < a)
                             && (4 * b * ax < a * span);
            end
            pipt_pkg::KIND_BOX: begin
                v.cfg_err  = (a == 0) || (b == 0) || (c == 0);
                v.in_shape = (2 * ax < a) && (2 * ay < b) && (2 * az < c);
            end
            pipt_pkg::KIND_SPHERE: begin
                v.cfg_err  = (a == 0);
                v.in_shape = s3 < a * a;
            end
            pipt_pkg::KIND_CONE: begin
                // radius grows linearly from zero at z = -b/2 to a at z = +b/2
                v.cfg_err  = (a == 0) || (b == 0);
                v.in_shape = (2 * az < b) && (4 * b * b * s2 < a * a * span * span);
            end
            pipt_pkg::KIND_CYLINDER: begin
                v.cfg_err  = (a == 0) || (b == 0);
                v.in_shape = (2 * az < b) && (s2 < a * a);
            end
            default: v.cfg_err = 1'b1;
        endcase
        if (v.cfg_err)
            v.in_shape = 1'b0;
        return v;
    endfunction

    // Mirror of a register write: wide data is cut to the register, spare
    // indexes change nothing.
    task automatic store_reg(input logic [pipt_pkg::IDX_W-1:0] idx,
                             input logic [pipt_pkg::DIM_W-1:0] val);
        case (idx)
            pipt_pkg::CFG_SHAPE_KIND:     kind_r  = val[2:0];
            pipt_pkg::CFG_DIM_A:          dim_a_r = val;
            pipt_pkg::CFG_DIM_B:          dim_b_r = val;
            pipt_pkg::CFG_DIM_C:          dim_c_r = val;
            pipt_pkg::CFG_FLAT_TOLERANCE: tol_r   = val[pipt_pkg::TOL_W-1:0];
            default: ;
        endcase
    endtask

    // Mostly no gap, else mostly short, occasionally long.
    function automatic int pick_gap(int idle_pct);
        if ($urandom_range(0, 99) >= idle_pct)
            return 0;
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Driving. All inputs change on the falling edge; handshakes are
    // sampled on the rising edge, before the block's registers move.
    // ------------------------------------------------------------------

    // Drop the request line and let every outstanding result arrive. Every
    // request yields exactly one result, so an empty store means an idle block.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_reg(input logic [pipt_pkg::IDX_W-1:0] idx,
                           input logic [pipt_pkg::DIM_W-1:0] val);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we    = 1'b0;
        store_reg(idx, val);
    endtask

    task automatic set_shape(input logic [2:0] kind,
                             input logic [pipt_pkg::DIM_W-1:0] a,
                             input logic [pipt_pkg::DIM_W-1:0] b,
                             input logic [pipt_pkg::DIM_W-1:0] c,
                             input logic [pipt_pkg::TOL_W-1:0] tol);
        set_reg(pipt_pkg::CFG_SHAPE_KIND, pipt_pkg::DIM_W'(kind));
        set_reg(pipt_pkg::CFG_DIM_A, a);
        set_reg(pipt_pkg::CFG_DIM_B, b);
        set_reg(pipt_pkg::CFG_DIM_C, c);
        set_reg(pipt_pkg::CFG_FLAT_TOLERANCE, pipt_pkg::DIM_W'(tol));
    endtask

    // One point request; returns on the falling edge after acceptance with
    // s_tvalid still high, so back-to-back requests leave no hole.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        int gap;
        gap = pick_gap(src_idle_pct);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {z, y, x};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_verdicts.push_back(classify_point(x, y, z));
        @(negedge aclk);
    endtask

    // Sink side: random stalls, plus one long hold-off when asked for.
    initial begin : sink_drive
        int stall_left;
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready = 1'b0;
            end else begin
                stall_left = pick_gap(sink_idle_pct);
                m_tready   = (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Result check against the oldest outstanding prediction.
    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with nothing outstanding, m_tdata %h", $time, m_tdata);
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[INSIDE_BIT] !== want.in_shape) begin
                    $display("%0t: inside_res expected %0b actual %0b", $time,
                             want.in_shape, m_tdata[INSIDE_BIT]);
                    fail_count++;
                end
                if (m_tdata[ERROR_BIT] !== want.cfg_err) begin
                    $display("%0t: config_error expected %0b actual %0b", $time,
                             want.cfg_err, m_tdata[ERROR_BIT]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long with no handshake on either side ends the run.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL point_in_primitive_test");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Shape straight out of reset: unit rect2d, tolerance of one LSB.
    task automatic test_reset_shape();
        send_point(32'd0, 32'd0, 32'd0);
        send_point(32'h7FFF, 32'd0, -32'h7FFF);       // just inside both half-widths
        send_point(32'h8000, 32'd0, 32'd0);           // on the edge, so outside
        send_point(MOST_NEG, MOST_POS, MOST_NEG);
    endtask

    // Every kind, unused code too, with the centre and an off-centre point.
    task automatic test_each_kind();
        logic [2:0] kind;
        kind = pipt_pkg::KIND_RECT2D;
        repeat (8) begin
            set_shape(kind, pipt_pkg::DIM_W'(2 * ONE), pipt_pkg::DIM_W'(2 * ONE),
                      pipt_pkg::DIM_W'(2 * ONE), 16'h8000);
            send_point(32'd0, 32'd0, 32'd0);
            send_point(ONE / 2, 32'h4000, ONE / 4);
            kind++;
        end
    endtask

    // Zero tolerance on a flat kind (no error), and missing dimensions.
    task automatic test_degenerate();
        set_shape(pipt_pkg::KIND_RECT2D, pipt_pkg::DIM_W'(ONE), pipt_pkg::DIM_W'(ONE),
                  pipt_pkg::DIM_W'(ONE), 16'd0);
        send_point(32'd0, 32'd0, 32'd0);
        set_shape(pipt_pkg::KIND_CONE, 31'd0, pipt_pkg::DIM_W'(ONE),
                  pipt_pkg::DIM_W'(ONE), 16'd1);
        send_point(32'd0, 32'd0, 32'd0);
        set_shape(pipt_pkg::KIND_BOX, pipt_pkg::DIM_W'(ONE), pipt_pkg::DIM_W'(ONE),
                  31'd0, 16'd1);
        send_point(32'd0, 32'd0, 32'd0);
    endtask

    // Largest dimensions against the most extreme coordinates.
    task automatic test_extremes();
        set_shape(pipt_pkg::KIND_SPHERE, DIM_MAX, DIM_MAX, DIM_MAX, 16'hFFFF);
        send_point(MOST_NEG, MOST_NEG, MOST_NEG);
        send_point(MOST_POS - 32'd1, 32'd0, 32'd0);
        set_shape(pipt_pkg::KIND_CONE, DIM_MAX, DIM_MAX, DIM_MAX, 16'hFFFF);
        send_point(32'd1, 32'hFFFF_FFFF, -32'h3FFF_FFFF);
    endtask

    // Over-wide writes are cut to the register; spare indexes are ignored.
    task automatic test_register_masking();
        logic [pipt_pkg::IDX_W-1:0] spare;
        set_shape(pipt_pkg::KIND_CIRCLE, pipt_pkg::DIM_W'(4 * ONE), pipt_pkg::DIM_W'(ONE),
                  pipt_pkg::DIM_W'(ONE), 16'd100);
        set_reg(pipt_pkg::CFG_FLAT_TOLERANCE, DIM_MAX);   // tolerance becomes 16'hFFFF
        spare = pipt_pkg::CFG_FLAT_TOLERANCE;
        repeat (2 ** pipt_pkg::IDX_W - 1 - pipt_pkg::CFG_FLAT_TOLERANCE) begin
            spare++;
            set_reg(spare, 31'd0);
        end
        send_point(ONE, 32'h0000_FFFE, -ONE);
        set_reg(pipt_pkg::CFG_SHAPE_KIND, DIM_MAX);       // kind becomes the unused code
        send_point(32'd0, 32'd0, 32'd0);
    endtask

    function automatic logic [pipt_pkg::DIM_W-1:0] rand_dim();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return DIM_MAX;
            2, 3:    return pipt_pkg::DIM_W'($urandom);
            default: return pipt_pkg::DIM_W'($urandom_range(1, 32'd1 << $urandom_range(4, 30)));
        endcase
    endfunction

    function automatic logic [pipt_pkg::TOL_W-1:0] rand_tol();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return pipt_pkg::TOL_W'($urandom_range(1, 16'hFFFF));
        endcase
    endfunction

    // Mostly within +/- extent so both sides of the boundary get hit; some
    // full-range words so every coordinate bit toggles, some corner values.
    function automatic logic [31:0] rand_coord(logic [31:0] extent);
        logic [31:0] m;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: case ($urandom_range(0, 4))
                   0:       return MOST_NEG;
                   1:       return MOST_POS;
                   2:       return 32'd0;
                   3:       return 32'd1;
                   default: return 32'hFFFF_FFFF;
               endcase
            default: begin
                m = $urandom_range(0, extent);
                return $urandom_range(0, 1) ? -m : m;
            end
        endcase
    endfunction

    // Three-quarters of a full width: half-width tests pass about 2/3 of the time.
    function automatic logic [31:0] spread(logic [31:0] d);
        return d - (d >> 2);
    endfunction

    task automatic test_random_shapes();
        logic [2:0]  kind;
        logic [31:0] ex, ey, ez;
        int          n;
        for (int phase = 0; phase < 18; phase++) begin
            kind = ($urandom_range(0, 19) == 0) ? KIND_UNUSED : 3'($urandom_range(0, 6));
            set_shape(kind, rand_dim(), rand_dim(), rand_dim(), rand_tol());
            case ($urandom_range(0, 3))
                0, 1: src_idle_pct = 0;
                2:    src_idle_pct = 15;
                default: src_idle_pct = 40;
            endcase
            case ($urandom_range(0, 3))
                0, 1: sink_idle_pct = 0;
                2:    sink_idle_pct = 15;
                default: sink_idle_pct = 40;
            endcase
            case (kind) inside
                pipt_pkg::KIND_RECT2D, pipt_pkg::KIND_TRIANGLE: begin
                    ex = spread(32'(dim_a_r));
                    ey = 32'(tol_r) + 32'(tol_r >> 1);
                    ez = spread(32'(dim_b_r));
                end
                pipt_pkg::KIND_CIRCLE: begin
                    ex = 32'(dim_a_r);
                    ey = 32'(tol_r) + 32'(tol_r >> 1);
                    ez = 32'(dim_a_r);
                end
                pipt_pkg::KIND_BOX: begin
                    ex = spread(32'(dim_a_r));
                    ey = spread(32'(dim_b_r));
                    ez = spread(32'(dim_c_r));
                end
                pipt_pkg::KIND_SPHERE: begin
                    ex = 32'(dim_a_r); ey = 32'(dim_a_r); ez = 32'(dim_a_r);
                end
                pipt_pkg::KIND_CONE, pipt_pkg::KIND_CYLINDER: begin
                    ex = 32'(dim_a_r); ey = 32'(dim_a_r); ez = spread(32'(dim_b_r));
                end
                default: begin
                    ex = MOST_POS; ey = MOST_POS; ez = MOST_POS;
                end
            endcase
            n = $urandom_range(35, 60);
            repeat (n)
                send_point(rand_coord(ex), rand_coord(ey), rand_coord(ez));
        end
    endtask

    // Sink holds off for a long stretch while requests keep coming back to
    // back: the pipe fills and s_tready has to drop, then everything drains.
    task automatic test_backpressure();
        set_shape(pipt_pkg::KIND_CYLINDER, pipt_pkg::DIM_W'(3 * ONE),
                  pipt_pkg::DIM_W'(5 * ONE), pipt_pkg::DIM_W'(ONE), 16'd1);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_request  = 1'b1;
        repeat (60)
            send_point(rand_coord(3 * ONE), rand_coord(3 * ONE), rand_coord(4 * ONE));
        sink_idle_pct = 20;
    endtask

    initial begin : run
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = pipt_pkg::CFG_SHAPE_KIND;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        hold_request  = 1'b0;
        fail_count    = 0;
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        // reset values of the shape registers
        kind_r  = pipt_pkg::KIND_RECT2D;
        dim_a_r = pipt_pkg::DIM_W'(ONE);
        dim_b_r = pipt_pkg::DIM_W'(ONE);
        dim_c_r = pipt_pkg::DIM_W'(ONE);
        tol_r   = pipt_pkg::TOL_W'(1);

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_shape();
        test_each_kind();
        test_degenerate();
        test_extremes();
        test_register_masking();
        test_random_shapes();
        test_backpressure();

        // let the last results out, then keep sampling to catch strays
        wait_drained();
        repeat (pipt_pkg::NSTAGE + 3) @(posedge aclk);
        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("PASS point_in_primitive_test");
        else
            $display("FAIL point_in_primitive_test");
        $finish;
    end

endmodule

>>> point_in_primitive_test.f
+incdir+rtl
rtl/pipt_pkg.sv
rtl/point_in_primitive_test.sv
dv/point_in_primitive_test_tb.sv
